[design/tox_pkg.sv]
// ----------------------------------------------------------------------------
// tox_pkg: shared types and constants of the transaction output extractor
// Holds the parse phase type, the result item layout and the result codes.
// ----------------------------------------------------------------------------
package tox_pkg;

  // Depth of the result queue at the top level.
  localparam int unsigned OUT_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SKIP_END = 3'd1;
  localparam logic [2:0] ERR_TRUNC    = 3'd2;
  localparam logic [2:0] ERR_FD       = 3'd3;
  localparam logic [2:0] ERR_FE       = 3'd4;
  localparam logic [2:0] ERR_FF       = 3'd5;

  typedef enum logic [4:0] {
    PH_TYPE     = 5'd0,
    PH_TYPE2    = 5'd1,
    PH_PAYVER   = 5'd2,
    PH_NATTR    = 5'd3,
    PH_USAGE    = 5'd4,
    PH_ATTRLEN  = 5'd5,
    PH_ATTRSKIP = 5'd6,
    PH_NIN      = 5'd7,
    PH_INSKIP   = 5'd8,
    PH_NOUT     = 5'd9,
    PH_ASSET    = 5'd10,
    PH_VALUE    = 5'd11,
    PH_OUTLOCK  = 5'd12,
    PH_HASH     = 5'd13,
    PH_OTYPE    = 5'd14,
    PH_VPVER    = 5'd15,
    PH_NCONT    = 5'd16,
    PH_VTYPE    = 5'd17,
    PH_NCAND    = 5'd18,
    PH_CANDLEN  = 5'd19,
    PH_CANDSKIP = 5'd20,
    PH_LOCK     = 5'd21
  } phase_e;

  // Walking state of the parser, without the assembled amount and hash.
  typedef struct packed {
    phase_e      phase;
    logic        new_ver;
    logic [7:0]  left;
    logic [7:0]  outer;
    logic [7:0]  cur;
    logic [7:0]  total;
    logic [7:0]  contents;
    logic [7:0]  cands;
  } tox_ctx_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [7:0]  output_index;
    logic [63:0] amount;
    logic [63:0] hash_head;
    logic [63:0] hash_mid;
    logic [39:0] hash_tail;
    logic        last_of_run;
  } tox_result_t;

  // What one accepted byte produces: up to two result items, in order.
  typedef struct packed {
    logic [1:0]  num;
    tox_result_t res0;
    tox_result_t res1;
  } tox_emit_t;

endpackage

[design/tox_in_if.sv]
// ----------------------------------------------------------------------------
// tox_in_if: byte input channel
// Valid/ready channel that carries one raw transaction byte per item.
// ----------------------------------------------------------------------------
interface tox_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[design/tox_out_if.sv]
// ----------------------------------------------------------------------------
// tox_out_if: result output channel
// Valid/ready channel that carries one extracted record, completion or error.
// ----------------------------------------------------------------------------
interface tox_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [7:0]  output_index;
  logic [63:0] amount;
  logic [63:0] hash_head;
  logic [63:0] hash_mid;
  logic [39:0] hash_tail;
  logic        last_of_run;

  modport source (
    output valid, output kind, output error_code, output output_index,
    output amount, output hash_head, output hash_mid, output hash_tail,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input error_code, input output_index,
    input amount, input hash_head, input hash_mid, input hash_tail,
    input last_of_run, output ready
  );
endinterface

[design/tox_parser.sv]
// ----------------------------------------------------------------------------
// tox_parser: transaction layout walker
// Advances the parse state by one byte per step and forms the results.
// ----------------------------------------------------------------------------
module tox_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output tox_pkg::tox_emit_t emit_o
);

  localparam logic [7:0] AssetLen = 8'd32;
  localparam logic [7:0] ValueLen = 8'd8;
  localparam logic [7:0] LockLen  = 8'd4;
  localparam logic [7:0] HashLen  = 8'd21;
  localparam logic [7:0] InLen    = 8'd38;
  localparam logic [7:0] NewVer   = 8'd9;

  // Walking state at the start of a transaction.
  localparam tox_pkg::tox_ctx_t CtxReset = '{
    phase:    tox_pkg::PH_TYPE,
    new_ver:  1'b0,
    left:     8'd0,
    outer:    8'd0,
    cur:      8'd0,
    total:    8'd0,
    contents: 8'd0,
    cands:    8'd0
  };

  tox_pkg::tox_ctx_t ctx_q, ctx_d, ctx_a, ctx_b;
  logic              ignore_q, ignore_d;
  logic [63:0]       amount_q, amount_d;
  logic [159:0]      hash_q, hash_d;
  logic [167:0]      hash_full;
  logic              cnt_phase, cnt_err, rec, done, other;
  logic [2:0]        err_code;
  tox_pkg::tox_result_t rec_res, oth_res;

  function automatic logic is_skip(tox_pkg::phase_e p);
    return p == tox_pkg::PH_ATTRSKIP || p == tox_pkg::PH_INSKIP ||
           p == tox_pkg::PH_ASSET || p == tox_pkg::PH_OUTLOCK ||
           p == tox_pkg::PH_CANDSKIP || p == tox_pkg::PH_LOCK;
  endfunction

  function automatic tox_pkg::tox_ctx_t after_output(tox_pkg::tox_ctx_t c);
    tox_pkg::tox_ctx_t r;
    r = c;
    r.cur = c.cur + 8'd1;
    if (r.cur < r.total) begin
      r.phase = tox_pkg::PH_ASSET;
      r.left  = AssetLen;
    end else begin
      r.phase = tox_pkg::PH_LOCK;
      r.left  = LockLen;
    end
    return r;
  endfunction

  function automatic tox_pkg::tox_ctx_t after_content(tox_pkg::tox_ctx_t c);
    tox_pkg::tox_ctx_t r;
    r = c;
    if (r.contents != 8'd0) r.contents = r.contents - 8'd1;
    if (r.contents != 8'd0) r.phase = tox_pkg::PH_VTYPE;
    else r = after_output(r);
    return r;
  endfunction

  assign hash_full = {hash_q, data_byte_i};

  // Work of the byte itself.
  always_comb begin
    cnt_phase = ctx_q.phase == tox_pkg::PH_NATTR || ctx_q.phase == tox_pkg::PH_ATTRLEN ||
                ctx_q.phase == tox_pkg::PH_NIN || ctx_q.phase == tox_pkg::PH_NOUT ||
                ctx_q.phase == tox_pkg::PH_NCONT || ctx_q.phase == tox_pkg::PH_NCAND ||
                ctx_q.phase == tox_pkg::PH_CANDLEN;
    cnt_err  = cnt_phase && (data_byte_i >= 8'hFD);
    ctx_a    = ctx_q;
    amount_d = amount_q;
    hash_d   = hash_q;
    rec      = 1'b0;
    unique case (ctx_q.phase)
      tox_pkg::PH_TYPE: begin
        ctx_a.new_ver = data_byte_i >= NewVer;
        ctx_a.phase   = (data_byte_i >= NewVer) ? tox_pkg::PH_TYPE2 : tox_pkg::PH_PAYVER;
      end
      tox_pkg::PH_TYPE2:  ctx_a.phase = tox_pkg::PH_PAYVER;
      tox_pkg::PH_PAYVER: ctx_a.phase = tox_pkg::PH_NATTR;
      tox_pkg::PH_NATTR: begin
        ctx_a.outer = data_byte_i;
        ctx_a.phase = (data_byte_i != 8'd0) ? tox_pkg::PH_USAGE : tox_pkg::PH_NIN;
      end
      tox_pkg::PH_USAGE: ctx_a.phase = tox_pkg::PH_ATTRLEN;
      tox_pkg::PH_ATTRLEN: begin
        ctx_a.phase = tox_pkg::PH_ATTRSKIP;
        ctx_a.left  = data_byte_i;
      end
      tox_pkg::PH_NIN: begin
        ctx_a.outer = data_byte_i;
        if (data_byte_i != 8'd0) begin
          ctx_a.phase = tox_pkg::PH_INSKIP;
          ctx_a.left  = InLen;
        end else begin
          ctx_a.phase = tox_pkg::PH_NOUT;
        end
      end
      tox_pkg::PH_NOUT: begin
        ctx_a.total = data_byte_i;
        ctx_a.cur   = 8'd0;
        if (data_byte_i != 8'd0) begin
          ctx_a.phase = tox_pkg::PH_ASSET;
          ctx_a.left  = AssetLen;
        end else begin
          ctx_a.phase = tox_pkg::PH_LOCK;
          ctx_a.left  = LockLen;
        end
      end
      tox_pkg::PH_VALUE: begin
        // Little-endian: each byte enters at the top and moves down.
        amount_d = {data_byte_i, amount_q[63:8]};
        if (ctx_q.left != 8'd0) ctx_a.left = ctx_q.left - 8'd1;
        if (ctx_a.left == 8'd0) begin
          ctx_a.phase = tox_pkg::PH_OUTLOCK;
          ctx_a.left  = LockLen;
        end
      end
      tox_pkg::PH_HASH: begin
        hash_d = hash_full[159:0];
        if (ctx_q.left != 8'd0) ctx_a.left = ctx_q.left - 8'd1;
        if (ctx_a.left == 8'd0) begin
          rec = 1'b1;
          if (ctx_q.new_ver) ctx_a.phase = tox_pkg::PH_OTYPE;
          else ctx_a = after_output(ctx_a);
        end
      end
      tox_pkg::PH_OTYPE: begin
        if (data_byte_i == 8'd1) ctx_a.phase = tox_pkg::PH_VPVER;
        else ctx_a = after_output(ctx_q);
      end
      tox_pkg::PH_VPVER: ctx_a.phase = tox_pkg::PH_NCONT;
      tox_pkg::PH_NCONT: begin
        ctx_a.contents = data_byte_i;
        if (data_byte_i != 8'd0) ctx_a.phase = tox_pkg::PH_VTYPE;
        else ctx_a = after_output(ctx_a);
      end
      tox_pkg::PH_VTYPE: ctx_a.phase = tox_pkg::PH_NCAND;
      tox_pkg::PH_NCAND: begin
        ctx_a.cands = data_byte_i;
        if (data_byte_i != 8'd0) ctx_a.phase = tox_pkg::PH_CANDLEN;
        else ctx_a = after_content(ctx_a);
      end
      tox_pkg::PH_CANDLEN: begin
        ctx_a.phase = tox_pkg::PH_CANDSKIP;
        ctx_a.left  = data_byte_i;
      end
      default: begin
        if (is_skip(ctx_q.phase)) begin
          if (ctx_q.left != 8'd0) ctx_a.left = ctx_q.left - 8'd1;
        end else begin
          ctx_a.phase = tox_pkg::PH_TYPE;
        end
      end
    endcase
  end

  // A finished skip moves on at once; one step always suffices because every
  // follow-up is either a non-skip phase or a skip of nonzero length.
  always_comb begin
    ctx_b = ctx_a;
    done  = 1'b0;
    if (!last_byte_i && is_skip(ctx_a.phase) && ctx_a.left == 8'd0) begin
      unique case (ctx_a.phase)
        tox_pkg::PH_ATTRSKIP: begin
          if (ctx_a.outer != 8'd0) ctx_b.outer = ctx_a.outer - 8'd1;
          ctx_b.phase = (ctx_b.outer != 8'd0) ? tox_pkg::PH_USAGE : tox_pkg::PH_NIN;
        end
        tox_pkg::PH_INSKIP: begin
          if (ctx_a.outer != 8'd0) ctx_b.outer = ctx_a.outer - 8'd1;
          if (ctx_b.outer != 8'd0) begin
            ctx_b.left = InLen;
          end else begin
            ctx_b.phase = tox_pkg::PH_NOUT;
          end
        end
        tox_pkg::PH_ASSET: begin
          ctx_b.phase = tox_pkg::PH_VALUE;
          ctx_b.left  = ValueLen;
        end
        tox_pkg::PH_OUTLOCK: begin
          ctx_b.phase = tox_pkg::PH_HASH;
          ctx_b.left  = HashLen;
        end
        tox_pkg::PH_CANDSKIP: begin
          if (ctx_a.cands != 8'd0) ctx_b.cands = ctx_a.cands - 8'd1;
          if (ctx_b.cands != 8'd0) ctx_b.phase = tox_pkg::PH_CANDLEN;
          else ctx_b = after_content(ctx_b);
        end
        default: begin
          done        = 1'b1;
          ctx_b.phase = tox_pkg::PH_TYPE;
        end
      endcase
    end
  end

  // Results and next state.
  always_comb begin
    unique case (data_byte_i[1:0])
      2'd1:    err_code = tox_pkg::ERR_FD;
      2'd2:    err_code = tox_pkg::ERR_FE;
      default: err_code = tox_pkg::ERR_FF;
    endcase

    rec_res              = '0;
    rec_res.kind         = tox_pkg::KIND_RECORD;
    rec_res.error_code   = tox_pkg::ERR_NONE;
    rec_res.output_index = ctx_q.cur;
    rec_res.amount       = amount_q;
    rec_res.hash_head    = hash_full[167:104];
    rec_res.hash_mid     = hash_full[103:40];
    rec_res.hash_tail    = hash_full[39:0];

    oth_res = '0;
    other   = 1'b0;
    if (cnt_err) begin
      other              = 1'b1;
      oth_res.kind       = tox_pkg::KIND_ERROR;
      oth_res.error_code = err_code;
    end else if (last_byte_i) begin
      other              = 1'b1;
      oth_res.kind       = tox_pkg::KIND_ERROR;
      oth_res.error_code = is_skip(ctx_a.phase) ? tox_pkg::ERR_SKIP_END : tox_pkg::ERR_TRUNC;
    end else if (done) begin
      other                = 1'b1;
      oth_res.kind         = tox_pkg::KIND_DONE;
      oth_res.output_index = ctx_b.total;
    end

    emit_o = '0;
    if (step_i && !ignore_q) begin
      if (rec && !cnt_err) begin
        emit_o.res0             = rec_res;
        emit_o.res0.last_of_run = !other;
        emit_o.res1             = oth_res;
        emit_o.res1.last_of_run = 1'b1;
        emit_o.num              = other ? 2'd2 : 2'd1;
      end else if (other) begin
        emit_o.res0             = oth_res;
        emit_o.res0.last_of_run = 1'b1;
        emit_o.num              = 2'd1;
      end
    end

    ctx_d    = ctx_q;
    ignore_d = ignore_q;
    if (step_i) begin
      if (last_byte_i) begin
        ctx_d    = CtxReset;
        ignore_d = 1'b0;
      end else if (!ignore_q) begin
        if (cnt_err) begin
          ignore_d = 1'b1;
        end else begin
          ctx_d    = ctx_b;
          ignore_d = done;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q    <= CtxReset;
      ignore_q <= 1'b0;
    end else begin
      ctx_q    <= ctx_d;
      ignore_q <= ignore_d;
    end
  end

  // Amount and hash assembly registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (step_i && !ignore_q && !cnt_err) begin
      amount_q <= amount_d;
      hash_q   <= hash_d;
    end
  end

endmodule

[design/transaction_output_extractor_core.sv]
// ----------------------------------------------------------------------------
// transaction_output_extractor_core: streaming transaction output extractor
// Walks a serialized transaction byte by byte and reports every output.
// ----------------------------------------------------------------------------
// The in_i channel takes one transaction byte per item; last_byte marks the
// final byte of a buffer. The out_o channel delivers result items: one record
// per output (index, amount and 21-byte program hash), then either a single
// completion item carrying the output count or a single error item.
// A byte is parsed in the cycle it is accepted, and its results are written
// into a small result queue at that clock edge, so with an empty queue the
// first result of a byte is visible on out_o in the cycle after acceptance.
// The block accepts one byte per cycle as long as the result queue has room
// for two items, the most that a single byte can cause (a record followed by
// an error when the last byte completes a program hash).
// A reset clears the parse state to the start of a transaction and empties
// the result queue. When the receiver stalls, results stay in the queue and
// in_i.ready drops once fewer than two entries are free; no result is lost.
// After an error or completion the following bytes are consumed without
// results up to and including the last byte of the buffer.
// ----------------------------------------------------------------------------
module transaction_output_extractor_core #(
  parameter int unsigned OutDepth = tox_pkg::OUT_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tox_in_if.sink    in_i,
  tox_out_if.source out_o
);

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);
  localparam logic [CntW-1:0] ReadyMax = CntW'(OutDepth - 2);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(OutDepth - 1);

  tox_pkg::tox_emit_t   emit;
  tox_pkg::tox_result_t queue_q [OutDepth];
  tox_pkg::tox_result_t head;
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, wr_ptr1, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 accept, pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  // Room for the worst case of two results decides readiness.
  assign in_i.ready = count_q <= ReadyMax;
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  tox_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .emit_o      (emit)
  );

  assign wr_ptr1 = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    unique case (emit.num)
      2'd1:    wr_ptr_d = wr_ptr1;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    if (pop) rd_ptr_d = ptr_inc(rd_ptr_q);
    count_d = count_q + CntW'(emit.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.num != 2'd0) queue_q[wr_ptr_q] <= emit.res0;
    if (emit.num == 2'd2) queue_q[wr_ptr1]  <= emit.res1;
  end

  assign head               = queue_q[rd_ptr_q];
  assign out_o.valid        = count_q != '0;
  assign out_o.kind         = head.kind;
  assign out_o.error_code   = head.error_code;
  assign out_o.output_index = head.output_index;
  assign out_o.amount       = head.amount;
  assign out_o.hash_head    = head.hash_head;
  assign out_o.hash_mid     = head.hash_mid;
  assign out_o.hash_tail    = head.hash_tail;
  assign out_o.last_of_run  = head.last_of_run;

endmodule

[design/tox_checker.sv]
// ----------------------------------------------------------------------------
// tox_checker: port-level checks of the transaction output extractor
// Watches the result channel and the input handshake over time.
// ----------------------------------------------------------------------------
module tox_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [2:0]  error_code_i,
  input logic [7:0]  output_index_i,
  input logic [63:0] amount_i,
  input logic        last_of_run_i
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(error_code_i) && $stable(amount_i) && $stable(output_index_i))
    else $error("stalled result changed");

  // Records carry no error code, errors always carry a real one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == tox_pkg::KIND_RECORD && error_code_i == tox_pkg::ERR_NONE) ||
    (kind_i == tox_pkg::KIND_DONE && error_code_i == tox_pkg::ERR_NONE) ||
    (kind_i == tox_pkg::KIND_ERROR && error_code_i != tox_pkg::ERR_NONE &&
     error_code_i <= tox_pkg::ERR_FF))
    else $error("kind and error code disagree");

  // Errors report neither index nor amount.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == tox_pkg::KIND_ERROR |-> output_index_i == 8'd0 && amount_i == 64'd0)
    else $error("error item carries data");

  // Only a record can be followed by another result of the same byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> kind_i == tox_pkg::KIND_RECORD)
    else $error("non-record item not last of its run");

  // Right after reset is released nothing is shown and the input is open.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i && in_ready_i)
    else $error("result present or input closed right after reset");

endmodule

bind transaction_output_extractor_core tox_checker u_tox_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .error_code_i   (out_o.error_code),
  .output_index_i (out_o.output_index),
  .amount_i       (out_o.amount),
  .last_of_run_i  (out_o.last_of_run)
);
